### rtl/core/mvd_pkg.sv
// shared types, constants and command codes for the mesh vertex dedup indexer
package mvd_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int MAP_DEPTH_DEF  = 256;

    localparam int CMD_W  = 2;
    localparam int ATTR_W = 32;
    localparam int REF_W  = 11;
    localparam int VIDX_W = 8;

    localparam logic [CMD_W-1:0] CMD_POS    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEX    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NORM   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CORNER = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ATTR_W-1:0] attr_a;
        logic [ATTR_W-1:0] attr_b;
        logic [ATTR_W-1:0] attr_c;
        logic [REF_W-1:0]  pos_ref;
        logic [REF_W-1:0]  tex_ref;
        logic [REF_W-1:0]  norm_ref;
    } t_in_item;

    typedef struct packed {
        logic [VIDX_W-1:0] vertex_index;
        logic              is_new;
        logic              error_flag;
        logic [ATTR_W-1:0] pos_x;
        logic [ATTR_W-1:0] pos_y;
        logic [ATTR_W-1:0] pos_z;
        logic [ATTR_W-1:0] tex_u;
        logic [ATTR_W-1:0] tex_v;
        logic [ATTR_W-1:0] norm_i;
        logic [ATTR_W-1:0] norm_j;
        logic [ATTR_W-1:0] norm_k;
    } t_out_item;

endpackage

### rtl/core/mvd_if.sv
// valid/ready stream interfaces for input items and result items
interface mvd_in_if import mvd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mvd_out_if import mvd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/mesh_vertex_dedup_indexer.sv
// top level: attribute pools, map cell chain and corner sequencer
// a load is written into its pool on accept, and an error result is registered on accept
// a face corner launches a search token that walks the map chain one cell a cycle
// one item at a time: next item taken once no search is pending and the result register is empty
// reset (synchronous, active low) clears pool counts, vertex count and map valid bits
// pool memories are not cleared; only written records are ever read
module mesh_vertex_dedup_indexer import mvd_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int MAP_DEPTH  = MAP_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvd_in_if.sink     i_in,
    mvd_out_if.source  o_out
);
    localparam int PA_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int RW    = (CNT_W > REF_W) ? CNT_W : REF_W;
    localparam int KEY_W = 3 * PA_W;
    localparam int IDX_W = $clog2(MAP_DEPTH);
    localparam int NV_W  = $clog2(MAP_DEPTH + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic r_state;

    // pool record counts and vertex count
    logic [CNT_W-1:0] r_cnt_pos, r_cnt_tex, r_cnt_norm;
    logic [NV_W-1:0]  r_next_vtx;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    // search token launch
    logic             r_launch;
    logic [KEY_W-1:0] r_key;

    t_in_item  item;
    logic      accept;
    assign item   = i_in.data;
    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept = i_in.valid && i_in.ready;

    // corner index checks, one-based against record counts
    logic [RW-1:0] pref, tref, nref;
    logic          refs_ok;
    logic [PA_W-1:0] pa, ta, na;
    assign pref = RW'(item.pos_ref);
    assign tref = RW'(item.tex_ref);
    assign nref = RW'(item.norm_ref);
    assign refs_ok = (pref != '0) && (pref <= RW'(r_cnt_pos))
                  && (tref != '0) && (tref <= RW'(r_cnt_tex))
                  && (nref != '0) && (nref <= RW'(r_cnt_norm));
    logic [RW-1:0] pm1, tm1, nm1;
    assign pm1 = pref - RW'(1);
    assign tm1 = tref - RW'(1);
    assign nm1 = nref - RW'(1);
    assign pa  = pm1[PA_W-1:0];
    assign ta  = tm1[PA_W-1:0];
    assign na  = nm1[PA_W-1:0];

    logic is_load, pool_full;
    always_comb begin
        is_load   = 1'b1;
        pool_full = 1'b0;
        case (item.command)
            CMD_POS:  pool_full = (r_cnt_pos  == CNT_W'(POOL_DEPTH));
            CMD_TEX:  pool_full = (r_cnt_tex  == CNT_W'(POOL_DEPTH));
            CMD_NORM: pool_full = (r_cnt_norm == CNT_W'(POOL_DEPTH));
            default:  is_load   = 1'b0;
        endcase
    end

    logic we_pos, we_tex, we_norm, rd_en;
    assign we_pos  = accept && (item.command == CMD_POS)  && !pool_full;
    assign we_tex  = accept && (item.command == CMD_TEX)  && !pool_full;
    assign we_norm = accept && (item.command == CMD_NORM) && !pool_full;
    assign rd_en   = accept && !is_load && refs_ok;

    logic [3*ATTR_W-1:0] pos_rd, norm_rd;
    logic [2*ATTR_W-1:0] tex_rd;

    mvd_ram #(.WIDTH(3*ATTR_W), .DEPTH(POOL_DEPTH)) u_pos_ram (
        .i_clk(i_clk), .i_we(we_pos), .i_waddr(r_cnt_pos[PA_W-1:0]),
        .i_wdata({item.attr_a, item.attr_b, item.attr_c}),
        .i_re(rd_en), .i_raddr(pa), .o_rdata(pos_rd)
    );
    mvd_ram #(.WIDTH(2*ATTR_W), .DEPTH(POOL_DEPTH)) u_tex_ram (
        .i_clk(i_clk), .i_we(we_tex), .i_waddr(r_cnt_tex[PA_W-1:0]),
        .i_wdata({item.attr_a, item.attr_b}),
        .i_re(rd_en), .i_raddr(ta), .o_rdata(tex_rd)
    );
    mvd_ram #(.WIDTH(3*ATTR_W), .DEPTH(POOL_DEPTH)) u_norm_ram (
        .i_clk(i_clk), .i_we(we_norm), .i_waddr(r_cnt_norm[PA_W-1:0]),
        .i_wdata({item.attr_a, item.attr_b, item.attr_c}),
        .i_re(rd_en), .i_raddr(na), .o_rdata(norm_rd)
    );

    // map cell chain, token enters cell 0 and leaves after the last cell
    logic             tok_v     [MAP_DEPTH+1];
    logic [KEY_W-1:0] tok_key   [MAP_DEPTH+1];
    logic             tok_found [MAP_DEPTH+1];
    logic [IDX_W-1:0] tok_idx   [MAP_DEPTH+1];
    logic             map_we;

    assign tok_v[0]     = r_launch;
    assign tok_key[0]   = r_key;
    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;

    for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_cell
        mvd_cell #(.KEY_W(KEY_W), .IDX_W(IDX_W), .CELL_IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_wr_en(map_we), .i_wr_addr(r_next_vtx[IDX_W-1:0]), .i_wr_key(r_key),
            .i_tok_v(tok_v[g]), .i_tok_key(tok_key[g]),
            .i_tok_found(tok_found[g]), .i_tok_idx(tok_idx[g]),
            .o_tok_v(tok_v[g+1]), .o_tok_key(tok_key[g+1]),
            .o_tok_found(tok_found[g+1]), .o_tok_idx(tok_idx[g+1])
        );
    end

    logic tok_done, map_full;
    assign tok_done = tok_v[MAP_DEPTH];
    assign map_full = (r_next_vtx == NV_W'(MAP_DEPTH));
    // new triple is entered at the next free cell when the search misses and the map is not full
    assign map_we   = tok_done && !tok_found[MAP_DEPTH] && !map_full;

    t_out_item err_item;
    always_comb begin
        err_item            = '0;
        err_item.error_flag = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_pos   <= '0;
            r_cnt_tex   <= '0;
            r_cnt_norm  <= '0;
            r_next_vtx  <= '0;
            r_out_valid <= 1'b0;
            r_launch    <= 1'b0;
        end else begin
            r_launch <= rd_en;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (we_pos)  r_cnt_pos  <= r_cnt_pos  + CNT_W'(1);
            if (we_tex)  r_cnt_tex  <= r_cnt_tex  + CNT_W'(1);
            if (we_norm) r_cnt_norm <= r_cnt_norm + CNT_W'(1);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if ((is_load && pool_full) || (!is_load && !refs_ok)) begin
                            r_out_valid <= 1'b1;
                        end else if (!is_load) begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (tok_done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (map_we) r_next_vtx <= r_next_vtx + NV_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // next result payload: error on accept, lookup outcome when the token leaves the chain
    t_out_item n_out;
    always_comb begin
        n_out = r_out;
        if (accept) begin
            n_out = err_item;
        end else if ((r_state == S_SEARCH) && tok_done) begin
            n_out = '0;
            if (tok_found[MAP_DEPTH]) begin
                n_out.vertex_index = VIDX_W'(tok_idx[MAP_DEPTH]);
            end else if (map_full) begin
                n_out = err_item;
            end else begin
                n_out.vertex_index = VIDX_W'(r_next_vtx);
                n_out.is_new       = 1'b1;
                n_out.pos_x        = pos_rd[3*ATTR_W-1:2*ATTR_W];
                n_out.pos_y        = pos_rd[2*ATTR_W-1:ATTR_W];
                n_out.pos_z        = pos_rd[ATTR_W-1:0];
                n_out.tex_u        = tex_rd[2*ATTR_W-1:ATTR_W];
                n_out.tex_v        = tex_rd[ATTR_W-1:0];
                n_out.norm_i       = norm_rd[3*ATTR_W-1:2*ATTR_W];
                n_out.norm_j       = norm_rd[2*ATTR_W-1:ATTR_W];
                n_out.norm_k       = norm_rd[ATTR_W-1:0];
            end
        end
    end

    // result payload and search key
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= {pa, ta, na};
        end
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

### rtl/core/mvd_ram.sv
// generic single-write, single-read ram with registered read data
module mvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/mvd_cell.sv
// one map cell: holds one triple key, matches the passing search token
module mvd_cell #(
    parameter int KEY_W    = 30,
    parameter int IDX_W    = 8,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_key,
    input  logic             i_tok_v,
    input  logic [KEY_W-1:0] i_tok_key,
    input  logic             i_tok_found,
    input  logic [IDX_W-1:0] i_tok_idx,
    output logic             o_tok_v,
    output logic [KEY_W-1:0] o_tok_key,
    output logic             o_tok_found,
    output logic [IDX_W-1:0] o_tok_idx
);
    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic             r_tok_v;
    logic [KEY_W-1:0] r_tok_key;
    logic             r_tok_found;
    logic [IDX_W-1:0] r_tok_idx;
    logic             hit;

    assign hit = r_valid && (r_key == i_tok_key) && !i_tok_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok_v <= 1'b0;
        end else begin
            if (i_wr_en && (i_wr_addr == IDX_W'(CELL_IDX))) begin
                r_valid <= 1'b1;
            end
            r_tok_v <= i_tok_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == IDX_W'(CELL_IDX))) begin
            r_key <= i_wr_key;
        end
        r_tok_key   <= i_tok_key;
        r_tok_found <= i_tok_found || hit;
        r_tok_idx   <= hit ? IDX_W'(CELL_IDX) : i_tok_idx;
    end

    assign o_tok_v     = r_tok_v;
    assign o_tok_key   = r_tok_key;
    assign o_tok_found = r_tok_found;
    assign o_tok_idx   = r_tok_idx;
endmodule
